/* hdl/som_pkg.sv */
// ----------------------------------------------------------------------------
// som_pkg
// Shared types, codes, widths and the neighborhood gain table of the
// self-organizing map block.
// ----------------------------------------------------------------------------
package som_pkg;

    localparam int MAX_NODES    = 64;
    localparam int MAX_ELEMENTS = 256;
    localparam int EXP_DEPTH    = 256;

    localparam int NODE_W   = 6;
    localparam int ELEM_W   = 8;
    localparam int VAL_W    = 16;
    localparam int EPOCH_W  = 16;
    localparam int DIST_W   = 40;
    localparam int LEAST_W  = 41;
    localparam int ADDR_W   = NODE_W + ELEM_W;
    localparam int GAIN_W   = 17;
    localparam int RATE_W   = 24;
    localparam int K_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [6:0]  RST_WIDTH  = 7'd8;
    localparam logic [6:0]  RST_HEIGHT = 7'd8;
    localparam logic [8:0]  RST_LENGTH = 9'd256;
    localparam logic [7:0]  RST_ALPHA  = 8'd1;
    localparam logic [15:0] RST_BETA   = 16'd4;

    // exp(-1/16) in Q0.32
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_MATCH = 2'd2,
        OP_TRAIN = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_MATCH = 2'd1,
        KIND_TRAIN = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_LENGTH = 3'd2,
        CFG_ALPHA  = 3'd3,
        CFG_BETA   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MUL_TT  = 3'd0,
        MUL_BB  = 3'd1,
        MUL_D2T = 3'd2,
        MUL_KB  = 3'd3,
        MUL_KB2 = 3'd4,
        MUL_RG  = 3'd5
    } t_mul_sel;

    typedef struct packed {
        logic     accept;
        logic     srch_start;
        logic     load_read;
        logic     load_match;
        logic     div_start;
        logic     node_first;
        logic     cap_tsq;
        logic     cap_bsq;
        logic     cap_d2;
        logic     cap_rhs;
        logic     k_step;
        logic     cap_g;
        logic     cap_cc;
        logic     upd_start;
        logic     node_next;
        t_mul_sel mul_sel;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic in_last;
        logic out_free;
        logic done;
        logic div_busy;
        logic bit_last;
        logic last_node;
        logic is_train;
    } t_status;

    function automatic logic [EXP_DEPTH*GAIN_W-1:0] exp_table_build();
        logic [EXP_DEPTH*GAIN_W-1:0] tab;
        logic [63:0] acc;
        logic [63:0] ent;
        tab = '0;
        acc = 64'h1_0000_0000;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            ent = (acc + 64'd32768) >> 16;
            tab[k*GAIN_W +: GAIN_W] = ent[GAIN_W-1:0];
            acc = (acc * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
        end
        return tab;
    endfunction

    localparam logic [EXP_DEPTH*GAIN_W-1:0] EXP_TABLE = exp_table_build();

    function automatic logic [GAIN_W-1:0] exp_gain(input logic [K_W-1:0] k);
        return EXP_TABLE[k*GAIN_W +: GAIN_W];
    endfunction

endpackage

/* hdl/som_match_and_train.sv */
// ----------------------------------------------------------------------------
// som_match_and_train
// Self-organizing map: weight access, best-match search and training step.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries one item: weight write, weight
// read, or one sample element for match or train. Output channel
// (o_valid / i_stall) returns read data, or the winner and its squared
// distance once the last sample element (vector_length-1, clamped to 0..255) arrives.
// A write or a non-final sample element leaves the input free. A read
// result passes through the weight memory output register and then the
// result register. A match walks every weight element through the single
// weight memory read port, one element a cycle. Training then adds rate
// division and setup, plus per node a gain search on the shared multiplier
// and an update pass; both run after the result is loaded.
// The result is loaded as soon as the search ends and the output is free.
// One item is in work at a time; o_stall stays high until it is finished.
// Reset restores the configuration defaults and drops any pending result;
// weight and sample memories hold no defined value until written.
// While the receiver stalls, the result register holds and the block waits
// before loading the next result.
// ----------------------------------------------------------------------------
module som_match_and_train (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [som_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [som_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_operation,
    input  logic [som_pkg::NODE_W-1:0]     i_node,
    input  logic [som_pkg::ELEM_W-1:0]     i_element,
    input  logic [som_pkg::VAL_W-1:0]      i_value,
    input  logic [som_pkg::EPOCH_W-1:0]    i_epoch,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_kind,
    output logic [som_pkg::VAL_W-1:0]      o_read_value,
    output logic [som_pkg::NODE_W-1:0]     o_winner,
    output logic [som_pkg::DIST_W-1:0]     o_best_distance
);

    som_pkg::t_cmd    cmd;
    som_pkg::t_status status;

    som_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    som_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_node          (i_node),
        .i_element       (i_element),
        .i_value         (i_value),
        .i_epoch         (i_epoch),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_read_value    (o_read_value),
        .o_winner        (o_winner),
        .o_best_distance (o_best_distance)
    );

endmodule

/* hdl/som_ctrl.sv */
// ----------------------------------------------------------------------------
// som_ctrl
// Sequencer: item dispatch, winner search, per-node neighborhood gain and
// weight update phases.
// ----------------------------------------------------------------------------
module som_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  som_pkg::t_status i_status,
    output som_pkg::t_cmd    o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_RDOUT  = 17'h00002,
        S_SEARCH = 17'h00004,
        S_MOUT   = 17'h00008,
        S_TSQ    = 17'h00010,
        S_BSQ    = 17'h00020,
        S_DIV    = 17'h00040,
        S_D2     = 17'h00080,
        S_RHS    = 17'h00100,
        S_CHK    = 17'h00200,
        S_KB     = 17'h00400,
        S_KB2    = 17'h00800,
        S_KCMP   = 17'h01000,
        S_GAIN   = 17'h02000,
        S_CC     = 17'h04000,
        S_CCAP   = 17'h08000,
        S_UPD    = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = som_pkg::MUL_TT;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.op == som_pkg::OP_READ) begin
                        n_state = S_RDOUT;
                    end else if ((i_status.op == som_pkg::OP_MATCH ||
                                  i_status.op == som_pkg::OP_TRAIN) && i_status.in_last) begin
                        o_cmd.srch_start = 1'b1;
                        n_state          = S_SEARCH;
                    end
                end
            end
            S_RDOUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_read = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (i_status.done) n_state = S_MOUT;
            end
            S_MOUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_match = 1'b1;
                    n_state          = i_status.is_train ? S_TSQ : S_IDLE;
                end
            end
            S_TSQ: begin
                o_cmd.mul_sel    = som_pkg::MUL_TT;
                o_cmd.div_start  = 1'b1;
                o_cmd.node_first = 1'b1;
                n_state          = S_BSQ;
            end
            S_BSQ: begin
                o_cmd.mul_sel = som_pkg::MUL_BB;
                o_cmd.cap_tsq = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                // hold the beta product in the multiplier register while dividing
                o_cmd.mul_sel = som_pkg::MUL_BB;
                o_cmd.cap_bsq = 1'b1;
                if (!i_status.div_busy) n_state = S_D2;
            end
            S_D2: begin
                o_cmd.cap_d2 = 1'b1;
                n_state      = S_RHS;
            end
            S_RHS: begin
                o_cmd.mul_sel = som_pkg::MUL_D2T;
                n_state       = S_CHK;
            end
            S_CHK: begin
                o_cmd.cap_rhs = 1'b1;
                n_state       = S_KB;
            end
            S_KB: begin
                o_cmd.mul_sel = som_pkg::MUL_KB;
                n_state       = S_KB2;
            end
            S_KB2: begin
                o_cmd.mul_sel = som_pkg::MUL_KB2;
                n_state       = S_KCMP;
            end
            S_KCMP: begin
                o_cmd.k_step = 1'b1;
                n_state      = i_status.bit_last ? S_GAIN : S_KB;
            end
            S_GAIN: begin
                o_cmd.cap_g = 1'b1;
                n_state     = S_CC;
            end
            S_CC: begin
                o_cmd.mul_sel = som_pkg::MUL_RG;
                n_state       = S_CCAP;
            end
            S_CCAP: begin
                o_cmd.cap_cc    = 1'b1;
                o_cmd.upd_start = 1'b1;
                n_state         = S_UPD;
            end
            S_UPD: begin
                if (i_status.done) begin
                    if (i_status.last_node) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.node_next = 1'b1;
                        n_state         = S_D2;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/som_dp.sv */
// ----------------------------------------------------------------------------
// som_dp
// Datapath: configuration registers, weight and sample memories, distance
// and update pipeline, gain search, rate divider and result register.
// ----------------------------------------------------------------------------
module som_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  som_pkg::t_cmd                        i_cmd,
    output som_pkg::t_status                     o_status,
    input  logic                                 i_cfg_we,
    input  logic [som_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [som_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [1:0]                           i_operation,
    input  logic [som_pkg::NODE_W-1:0]           i_node,
    input  logic [som_pkg::ELEM_W-1:0]           i_element,
    input  logic [som_pkg::VAL_W-1:0]            i_value,
    input  logic [som_pkg::EPOCH_W-1:0]          i_epoch,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [1:0]                           o_kind,
    output logic [som_pkg::VAL_W-1:0]            o_read_value,
    output logic [som_pkg::NODE_W-1:0]           o_winner,
    output logic [som_pkg::DIST_W-1:0]           o_best_distance
);

    localparam int NW = som_pkg::NODE_W;
    localparam int EW = som_pkg::ELEM_W;
    localparam int VW = som_pkg::VAL_W;
    localparam int RW = som_pkg::RATE_W;

    // configuration
    logic [6:0]  r_map_width;
    logic [6:0]  r_map_height;
    logic [8:0]  r_vector_length;
    logic [7:0]  r_alpha;
    logic [15:0] r_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width     <= som_pkg::RST_WIDTH;
            r_map_height    <= som_pkg::RST_HEIGHT;
            r_vector_length <= som_pkg::RST_LENGTH;
            r_alpha         <= som_pkg::RST_ALPHA;
            r_beta          <= som_pkg::RST_BETA;
        end else if (i_cfg_we) begin
            case (som_pkg::t_cfg_idx'(i_cfg_index))
                som_pkg::CFG_WIDTH:  r_map_width     <= i_cfg_data[6:0];
                som_pkg::CFG_HEIGHT: r_map_height    <= i_cfg_data[6:0];
                som_pkg::CFG_LENGTH: r_vector_length <= i_cfg_data[8:0];
                som_pkg::CFG_ALPHA:  r_alpha         <= i_cfg_data[7:0];
                som_pkg::CFG_BETA:   r_beta          <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [6:0]    w_eff;
    logic [6:0]    h_eff;
    logic [13:0]   node_prod;
    logic [NW-1:0] last_node;
    logic [EW-1:0] last_elem;

    assign w_eff     = (r_map_width == 7'd0) ? 7'd1 : r_map_width;
    assign h_eff     = (r_map_height == 7'd0) ? 7'd1 : r_map_height;
    assign node_prod = {7'd0, w_eff} * {7'd0, h_eff};
    assign last_node = (node_prod >= 14'(som_pkg::MAX_NODES)) ? NW'(som_pkg::MAX_NODES - 1)
                                                               : NW'(node_prod - 14'd1);
    assign last_elem = (r_vector_length == 9'd0) ? '0 :
                       (r_vector_length >= 9'(som_pkg::MAX_ELEMENTS)) ?
                           EW'(som_pkg::MAX_ELEMENTS - 1) : EW'(r_vector_length - 9'd1);

    // item capture
    som_pkg::t_op in_op;
    logic         r_is_train;
    logic [15:0]  r_t;

    assign in_op = som_pkg::t_op'(i_operation);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_train <= (in_op == som_pkg::OP_TRAIN);
            r_t        <= (i_epoch == 16'd0) ? 16'd1 : i_epoch;
        end
    end

    // node / element walk
    logic [NW-1:0] r_node;
    logic [NW-1:0] r_col;
    logic [NW-1:0] r_row;
    logic [EW-1:0] r_elem;
    logic          r_iss;
    logic          r_train;
    logic          adv_node;

    assign adv_node = (r_iss && !r_train && r_elem == last_elem) || i_cmd.node_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss   <= 1'b0;
            r_train <= 1'b0;
        end else begin
            if (r_iss) begin
                if (r_elem == last_elem) begin
                    r_elem <= '0;
                    if (r_train || r_node == last_node) r_iss <= 1'b0;
                end else begin
                    r_elem <= r_elem + 1'b1;
                end
            end
            if (adv_node) begin
                r_node <= r_node + 1'b1;
                if ({1'b0, r_col} == w_eff - 7'd1) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (i_cmd.node_first) begin
                r_node <= '0;
                r_col  <= '0;
                r_row  <= '0;
            end
            if (i_cmd.srch_start) begin
                r_node  <= '0;
                r_col   <= '0;
                r_row   <= '0;
                r_elem  <= '0;
                r_iss   <= 1'b1;
                r_train <= 1'b0;
            end
            if (i_cmd.upd_start) begin
                r_elem  <= '0;
                r_iss   <= 1'b1;
                r_train <= 1'b1;
            end
        end
    end

    // memories
    logic [VW-1:0] r_wmem [som_pkg::MAX_NODES*som_pkg::MAX_ELEMENTS];
    logic [VW-1:0] r_smem [som_pkg::MAX_ELEMENTS];
    logic [VW-1:0] r_wq;
    logic [VW-1:0] r_sq;

    logic                      w_re;
    logic                      w_we;
    logic [som_pkg::ADDR_W-1:0] w_raddr;
    logic [som_pkg::ADDR_W-1:0] w_waddr;
    logic [VW-1:0]             w_wdata;
    logic                      s_we;

    // pipeline tags
    logic          r_p1_v, r_p1_first, r_p1_last, r_p1_final;
    logic [NW-1:0] r_p1_node, r_p1_col, r_p1_row;
    logic [EW-1:0] r_p1_elem;
    logic          r_p2_v, r_p2_first, r_p2_last, r_p2_final, r_p2_neg;
    logic [NW-1:0] r_p2_node, r_p2_col, r_p2_row;
    logic [EW-1:0] r_p2_elem;
    logic [VW-1:0] r_p2_cur;
    logic [39:0]   r_p2_prod;
    logic          r_done;

    logic [RW-1:0] r_cc;
    logic [VW-1:0] mag;
    logic [RW-1:0] mult_a;
    logic [RW-1:0] step;
    logic [24:0]   up_sum;
    logic [VW-1:0] new_w;

    assign w_re    = (i_cmd.accept && in_op == som_pkg::OP_READ) || r_iss;
    assign w_raddr = i_cmd.accept ? {i_node, i_element} : {r_node, r_elem};
    assign w_we    = (i_cmd.accept && in_op == som_pkg::OP_WRITE) || (r_p2_v && r_train);
    assign w_waddr = i_cmd.accept ? {i_node, i_element} : {r_p2_node, r_p2_elem};
    assign w_wdata = i_cmd.accept ? i_value : new_w;
    assign s_we    = i_cmd.accept && (in_op == som_pkg::OP_MATCH || in_op == som_pkg::OP_TRAIN);

    always_ff @(posedge i_clk) begin
        if (w_we) r_wmem[w_waddr] <= w_wdata;
        if (w_re) r_wq <= r_wmem[w_raddr];
        if (s_we) r_smem[i_element] <= i_value;
        if (r_iss) r_sq <= r_smem[r_elem];
    end

    assign mag    = (r_sq >= r_wq) ? (r_sq - r_wq) : (r_wq - r_sq);
    assign mult_a = r_train ? r_cc : {8'd0, mag};
    assign step   = r_p2_prod[39:16];
    assign up_sum = {9'd0, r_p2_cur} + {1'b0, step};

    always_comb begin
        if (r_p2_neg) begin
            new_w = (step > {8'd0, r_p2_cur}) ? '0 : (r_p2_cur - step[VW-1:0]);
        end else begin
            new_w = (up_sum > 25'h00FFFF) ? 16'hFFFF : up_sum[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_p1_v <= r_iss;
            r_p2_v <= r_p1_v;
            r_done <= r_p2_v && r_p2_last && (r_train || r_p2_final);
        end
        r_p1_first <= (r_elem == '0);
        r_p1_last  <= (r_elem == last_elem);
        r_p1_final <= (r_node == last_node);
        r_p1_node  <= r_node;
        r_p1_col   <= r_col;
        r_p1_row   <= r_row;
        r_p1_elem  <= r_elem;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_final <= r_p1_final;
        r_p2_node  <= r_p1_node;
        r_p2_col   <= r_p1_col;
        r_p2_row   <= r_p1_row;
        r_p2_elem  <= r_p1_elem;
        r_p2_cur   <= r_wq;
        r_p2_neg   <= (r_sq < r_wq);
        r_p2_prod  <= mult_a * mag;
    end

    // winner search
    logic [som_pkg::DIST_W-1:0]  r_acc;
    logic [som_pkg::DIST_W-1:0]  acc_n;
    logic [som_pkg::LEAST_W-1:0] r_least;
    logic [NW-1:0]               r_best;
    logic [NW-1:0]               r_bcol;
    logic [NW-1:0]               r_brow;

    assign acc_n = (r_p2_first ? '0 : r_acc) + {8'd0, r_p2_prod[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.srch_start) begin
            r_least <= '1;
            r_best  <= '0;
            r_bcol  <= '0;
            r_brow  <= '0;
        end else if (r_p2_v && !r_train) begin
            r_acc <= acc_n;
            // strict compare keeps the lowest index on ties
            if (r_p2_last && {1'b0, acc_n} < r_least) begin
                r_least <= {1'b0, acc_n};
                r_best  <= r_p2_node;
                r_bcol  <= r_p2_col;
                r_brow  <= r_p2_row;
            end
        end
    end

    // shared multiplier for setup and per-node gain
    logic [RW-1:0]   mul_a;
    logic [31:0]     mul_b;
    logic [55:0]     r_prod;
    logic [31:0]     r_tsq;
    logic [31:0]     r_bsq;
    logic [12:0]     r_d2;
    logic [52:0]     r_rhs;
    logic [7:0]      r_k;
    logic [7:0]      r_bit;
    logic [7:0]      trial;
    logic [som_pkg::GAIN_W-1:0] r_g;
    logic [RW-1:0]   rate;
    logic [NW-1:0]   adx;
    logic [NW-1:0]   ady;
    logic [11:0]     sq_x;
    logic [11:0]     sq_y;

    assign trial = r_k | r_bit;
    assign adx   = (r_col >= r_bcol) ? (r_col - r_bcol) : (r_bcol - r_col);
    assign ady   = (r_row >= r_brow) ? (r_row - r_brow) : (r_brow - r_row);
    assign sq_x  = adx * adx;
    assign sq_y  = ady * ady;

    always_comb begin
        case (i_cmd.mul_sel)
            som_pkg::MUL_TT:  begin mul_a = {8'd0, r_t};           mul_b = {16'd0, r_t};    end
            som_pkg::MUL_BB:  begin mul_a = {8'd0, r_beta};        mul_b = {16'd0, r_beta}; end
            som_pkg::MUL_D2T: begin mul_a = {11'd0, r_d2};         mul_b = r_tsq;           end
            som_pkg::MUL_KB:  begin mul_a = {16'd0, trial};        mul_b = {16'd0, r_beta}; end
            som_pkg::MUL_KB2: begin mul_a = r_prod[23:0];          mul_b = {8'd0, r_prod[23:0]}; end
            som_pkg::MUL_RG:  begin mul_a = rate;                  mul_b = {15'd0, r_g};    end
            default:          begin mul_a = '0;                    mul_b = '0;              end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.cap_tsq) r_tsq <= r_prod[31:0];
        if (i_cmd.cap_bsq) r_bsq <= r_prod[31:0];
        if (i_cmd.cap_d2)  r_d2  <= {1'b0, sq_x} + {1'b0, sq_y};
        if (i_cmd.cap_rhs) begin
            r_rhs <= {r_prod[44:0], 8'd0};
            r_k   <= '0;
            r_bit <= 8'h80;
        end
        if (i_cmd.k_step) begin
            if ({5'd0, r_prod[47:0]} <= r_rhs) r_k <= trial;
            r_bit <= r_bit >> 1;
        end
        if (i_cmd.cap_g) begin
            if (r_beta == 16'd0) begin
                r_g <= (r_d2 == 13'd0) ? 17'h10000 : '0;
            end else if ({5'd0, r_bsq, 16'd0} <= r_rhs) begin
                r_g <= '0;
            end else begin
                r_g <= som_pkg::exp_gain(r_k);
            end
        end
        if (i_cmd.cap_cc) r_cc <= r_prod[39:16];
    end

    // rate divider: alpha*65536 / t, one quotient bit a cycle
    logic [RW-1:0] r_div_q;
    logic [15:0]   r_div_rem;
    logic [4:0]    r_div_cnt;
    logic          r_div_busy;
    logic [16:0]   rem_sh;

    assign rem_sh = {r_div_rem, r_div_q[RW-1]};
    assign rate   = (r_alpha == 8'd0) ? 24'h010000 : r_div_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_div_q    <= {r_alpha, 16'd0};
            r_div_rem  <= '0;
            r_div_cnt  <= 5'(RW);
            r_div_busy <= 1'b1;
        end else if (r_div_busy) begin
            if (rem_sh >= {1'b0, r_t}) begin
                r_div_rem <= 16'(rem_sh - {1'b0, r_t});
                r_div_q   <= {r_div_q[RW-2:0], 1'b1};
            end else begin
                r_div_rem <= rem_sh[15:0];
                r_div_q   <= {r_div_q[RW-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt - 5'd1;
            if (r_div_cnt == 5'd1) r_div_busy <= 1'b0;
        end
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_read) begin
            r_out_valid     <= 1'b1;
            o_kind          <= som_pkg::KIND_READ;
            o_read_value    <= r_wq;
            o_winner        <= '0;
            o_best_distance <= '0;
        end else if (i_cmd.load_match) begin
            r_out_valid     <= 1'b1;
            o_kind          <= r_is_train ? som_pkg::KIND_TRAIN : som_pkg::KIND_MATCH;
            o_read_value    <= '0;
            o_winner        <= r_best;
            o_best_distance <= r_least[som_pkg::LEAST_W-1] ? '1
                                                           : r_least[som_pkg::DIST_W-1:0];
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    assign o_status.op        = in_op;
    assign o_status.in_last   = (i_element == last_elem);
    assign o_status.out_free  = !r_out_valid || !i_stall;
    assign o_status.done      = r_done;
    assign o_status.div_busy  = r_div_busy;
    assign o_status.bit_last  = r_bit[0];
    assign o_status.last_node = (r_node == last_node);
    assign o_status.is_train  = r_is_train;

endmodule

/* hdl/som_checker.sv */
// ----------------------------------------------------------------------------
// som_checker
// Port-level checks of the self-organizing map block.
// ----------------------------------------------------------------------------
module som_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [som_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [som_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [1:0]                     i_operation,
    input logic [som_pkg::NODE_W-1:0]     i_node,
    input logic [som_pkg::ELEM_W-1:0]     i_element,
    input logic [som_pkg::VAL_W-1:0]      i_value,
    input logic [som_pkg::EPOCH_W-1:0]    i_epoch,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [1:0]                     o_kind,
    input logic [som_pkg::VAL_W-1:0]      o_read_value,
    input logic [som_pkg::NODE_W-1:0]     o_winner,
    input logic [som_pkg::DIST_W-1:0]     o_best_distance
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_read_value) &&
                               $stable(o_winner) && $stable(o_best_distance))
        else $error("result changed while stalled");

    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == som_pkg::KIND_READ |-> o_winner == '0 && o_best_distance == '0)
        else $error("read result carries match fields");

    a_match_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != som_pkg::KIND_READ |-> o_read_value == '0)
        else $error("match result carries read data");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_operation == som_pkg::OP_READ |=> o_stall)
        else $error("read transfer did not hold off the input");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_operation == som_pkg::OP_WRITE |=> !o_stall)
        else $error("write transfer stalled the input");

endmodule

bind som_match_and_train som_checker u_som_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for som_match_and_train. A directed table covers weight
// access, epoch zero and the winner-only update; random sample sequences then
// run over several map shapes. Each result is compared with the expected
// result of its directed row, or with a behavioral map model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        som_pkg::t_op op;
        logic [5:0]   node;
        logic [7:0]   elem;
        logic [15:0]  val;
        logic [15:0]  epoch;
    } t_item;

    typedef struct {
        som_pkg::t_kind kind;
        logic [15:0]    rv;
        logic [5:0]     win;
        logic [39:0]    bdist;
    } t_res;

    typedef struct {
        t_item it;
        bit    typed;
        t_res  res;
    } t_row;

    localparam logic [40:0] LEAST_INIT = {41{1'b1}};
    localparam logic [39:0] DIST_MAX   = {40{1'b1}};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation = '0;
    logic [5:0]  i_node = '0;
    logic [7:0]  i_element = '0;
    logic [15:0] i_value = '0;
    logic [15:0] i_epoch = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [15:0] o_read_value;
    logic [5:0]  o_winner;
    logic [39:0] o_best_distance;

    som_match_and_train uut (.*);

    always #5 i_clk = ~i_clk;

    // map model
    logic [15:0] weight_mem [64][256];
    bit          wt_written [64][256];
    logic [15:0] sample_mem [256];
    logic [16:0] gain_tab [256];
    logic [6:0]  map_w, map_h;
    logic [8:0]  vec_len;
    logic [7:0]  alpha_r;
    logic [15:0] beta_r;
    logic [40:0] least_dist;
    int          best_idx;

    t_res        result_q[$];
    t_row        dir_tab[$];
    int          n_fail = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_train = 0;
    bit          quiet = 0;
    bit          hold_req = 0;

    function automatic int eff_w();
        return (map_w == 0) ? 1 : int'(map_w);
    endfunction

    function automatic int node_total();
        int n;
        n = eff_w() * ((map_h == 0) ? 1 : int'(map_h));
        return (n > 64) ? 64 : n;
    endfunction

    function automatic int len_total();
        int l;
        l = (vec_len == 0) ? 1 : int'(vec_len);
        return (l > 256) ? 256 : l;
    endfunction

    function automatic int settle_cycles();
        return node_total() * (len_total() + 40) + 200;
    endfunction

    task automatic build_gain_table();
        bit [63:0] acc;
        acc = 64'h1_0000_0000;
        for (int k = 0; k < 256; k++) begin
            gain_tab[k] = 17'((acc + 64'd32768) >> 16);
            acc = (acc * 64'd4034748382 + 64'h8000_0000) >> 32;
        end
    endtask

    function automatic longint unsigned neighbor_gain(longint unsigned d2, longint unsigned t);
        longint unsigned b2, rhs, lo, hi, mid;
        if (beta_r == 0) return (d2 == 0) ? 65536 : 0;
        b2 = longint'(beta_r) * longint'(beta_r);
        rhs = 256 * d2 * t * t;
        if (65536 * b2 <= rhs) return 0;
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * b2 <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return gain_tab[lo];
    endfunction

    task automatic search_best(input int nodes, input int len);
        longint unsigned sum;
        longint d;
        least_dist = LEAST_INIT;
        best_idx = 0;
        for (int i = 0; i < nodes; i++) begin
            sum = 0;
            for (int j = 0; j < len; j++) begin
                d = longint'(weight_mem[i][j]) - longint'(sample_mem[j]);
                sum += longint'(d * d);
                if (sum > LEAST_INIT) sum = LEAST_INIT;
            end
            if (sum < least_dist) begin
                least_dist = 41'(sum);
                best_idx = i;
            end
        end
    endtask

    task automatic train_map(input int nodes, input int len, input longint unsigned t);
        longint unsigned rate, cc, mag, d2;
        longint wx, wy, dx, dy, diff, step, nw;
        int w;
        w = eff_w();
        rate = (alpha_r != 0) ? (longint'(alpha_r) * 65536) / t : 65536;
        wx = best_idx % w;
        wy = best_idx / w;
        for (int i = 0; i < nodes; i++) begin
            dx = (i % w) - wx;
            dy = (i / w) - wy;
            d2 = dx * dx + dy * dy;
            cc = (rate * neighbor_gain(d2, t)) >> 16;
            for (int j = 0; j < len; j++) begin
                diff = longint'(sample_mem[j]) - longint'(weight_mem[i][j]);
                mag = (diff < 0) ? -diff : diff;
                step = (cc * mag) >> 16;
                nw = (diff < 0) ? weight_mem[i][j] - step : weight_mem[i][j] + step;
                if (nw < 0) nw = 0;
                if (nw > 65535) nw = 65535;
                weight_mem[i][j] = 16'(nw);
            end
        end
    endtask

    task automatic map_predict(input t_item it, output bit has, output t_res r);
        longint unsigned t;
        int len, nodes;
        t = (it.epoch == 0) ? 1 : it.epoch;
        has = 0;
        r = '{som_pkg::KIND_READ, 16'd0, 6'd0, 40'd0};
        case (it.op)
            som_pkg::OP_WRITE: begin
                weight_mem[it.node][it.elem] = it.val;
                wt_written[it.node][it.elem] = 1;
            end
            som_pkg::OP_READ: begin
                has = 1;
                r.rv = weight_mem[it.node][it.elem];
            end
            default: begin
                sample_mem[it.elem] = it.val;
                len = len_total();
                if (int'(it.elem) == len - 1) begin
                    nodes = node_total();
                    search_best(nodes, len);
                    has = 1;
                    r.kind = (it.op == som_pkg::OP_TRAIN) ? som_pkg::KIND_TRAIN
                                                          : som_pkg::KIND_MATCH;
                    r.win = 6'(best_idx);
                    r.bdist = (least_dist > DIST_MAX) ? DIST_MAX : least_dist[39:0];
                    if (it.op == som_pkg::OP_TRAIN) begin
                        train_map(nodes, len, t);
                        n_train++;
                    end
                end
            end
        endcase
    endtask

    // offer one transfer; hold it until the block takes it
    task automatic send(input t_item it, input bit typed = 0,
                        input t_res typed_res = '{som_pkg::KIND_READ, 16'd0, 6'd0, 40'd0});
        bit has;
        t_res r;
        i_valid <= 1'b1;
        i_operation <= it.op;
        i_node <= it.node;
        i_element <= it.elem;
        i_value <= it.val;
        i_epoch <= it.epoch;
        do @(posedge i_clk); while (o_stall);
        n_items++;
        map_predict(it, has, r);
        if (has) result_q.push_back(typed ? typed_res : r);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (result_q.size() != 0 && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (settle_cycles()) @(posedge i_clk);
    endtask

    task automatic cfg_write(input som_pkg::t_cfg_idx idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            som_pkg::CFG_WIDTH:  map_w = data[6:0];
            som_pkg::CFG_HEIGHT: map_h = data[6:0];
            som_pkg::CFG_LENGTH: vec_len = data[8:0];
            som_pkg::CFG_ALPHA:  alpha_r = data[7:0];
            default:             beta_r = data;
        endcase
    endtask

    task automatic set_map(input int w, input int h, input int l, input int a, input int b);
        cfg_write(som_pkg::CFG_WIDTH, 16'(w));
        cfg_write(som_pkg::CFG_HEIGHT, 16'(h));
        cfg_write(som_pkg::CFG_LENGTH, 16'(l));
        cfg_write(som_pkg::CFG_ALPHA, 16'(a));
        cfg_write(som_pkg::CFG_BETA, 16'(b));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_item mk(som_pkg::t_op op, int node, int elem, int val, int ep);
        t_item it;
        it.op = op;
        it.node = 6'(node);
        it.elem = 8'(elem);
        it.val = 16'(val);
        it.epoch = 16'(ep);
        return it;
    endfunction

    task automatic add_row(input t_item it, input bit typed = 0,
                           input som_pkg::t_kind k = som_pkg::KIND_READ,
                           input int rv = 0, input int win = 0, input longint bdist = 0);
        t_row row;
        row.it = it;
        row.typed = typed;
        row.res = '{k, 16'(rv), 6'(win), 40'(bdist)};
        dir_tab.push_back(row);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // write every weight the current map will search
    task automatic fill_weights();
        for (int n = 0; n < node_total(); n++)
            for (int e = 0; e < len_total(); e++)
                if (!wt_written[n][e]) send(mk(som_pkg::OP_WRITE, n, e, rand_value(), 1));
    endtask

    task automatic random_read();
        int n, e;
        for (int k = 0; k < 20; k++) begin
            n = $urandom_range(0, 63);
            e = $urandom_range(0, 255);
            if (k > 10) begin
                n = $urandom_range(0, node_total() - 1);
                e = $urandom_range(0, len_total() - 1);
            end
            if (wt_written[n][e]) begin
                send(mk(som_pkg::OP_READ, n, e, $urandom_range(0, 65535),
                        $urandom_range(0, 65535)));
                return;
            end
        end
    endtask

    task automatic noise_item();
        int l;
        l = len_total();
        case ($urandom_range(0, 2))
            0: send(mk(som_pkg::OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 255),
                       rand_value(), $urandom_range(0, 65535)));
            1: random_read();
            default: if (l < 256)
                send(mk($urandom_range(0, 1) ? som_pkg::OP_TRAIN : som_pkg::OP_MATCH,
                        $urandom_range(0, 63), $urandom_range(l, 255), rand_value(),
                        $urandom_range(0, 65535)));
        endcase
    endtask

    task automatic run_sequences(input int count);
        som_pkg::t_op op;
        int ep, l, stop;
        l = len_total();
        for (int s = 0; s < count; s++) begin
            op = $urandom_range(0, 1) ? som_pkg::OP_TRAIN : som_pkg::OP_MATCH;
            ep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 16);
            // some sequences break off before the last element
            stop = ($urandom_range(0, 9) == 0) ? $urandom_range(0, l - 1) : l;
            for (int e = 0; e < stop; e++) begin
                if ($urandom_range(0, 7) == 0) noise_item();
                send(mk(op, $urandom_range(0, 63), e, rand_value(), ep));
            end
        end
    endtask

    task automatic run_phase(input int w, input int h, input int l, input int a, input int b,
                             input int seqs);
        set_map(w, h, l, a, b);
        fill_weights();
        run_sequences(seqs);
        drain();
    endtask

    // receiver side: random stall bursts, plus one long hold on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                gap = 0;
                while (gap < 400) begin
                    @(posedge i_clk);
                    gap++;
                end
                i_stall <= 1'b0;
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (result_q.size() == 0) begin
                $error("unexpected result kind=%0d", o_kind);
                n_fail++;
            end else begin
                e = result_q.pop_front();
                if (o_kind != e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, o_kind);
                    n_fail++;
                end
                if (o_read_value != e.rv) begin
                    $error("read_value: expected %0h, got %0h", e.rv, o_read_value);
                    n_fail++;
                end
                if (o_winner != e.win) begin
                    $error("winner: expected %0d, got %0d", e.win, o_winner);
                    n_fail++;
                end
                if (o_best_distance != e.bdist) begin
                    $error("best_distance: expected %0d, got %0d", e.bdist, o_best_distance);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        map_w = som_pkg::RST_WIDTH;
        map_h = som_pkg::RST_HEIGHT;
        vec_len = som_pkg::RST_LENGTH;
        alpha_r = som_pkg::RST_ALPHA;
        beta_r = som_pkg::RST_BETA;
        build_gain_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 2x2 map, two elements, rate one, winner only
        set_map(2, 2, 2, 0, 0);
        add_row(mk(som_pkg::OP_WRITE, 0, 0, 16'hFFFF, 1));
        add_row(mk(som_pkg::OP_WRITE, 0, 1, 16'hFFFF, 1));
        add_row(mk(som_pkg::OP_WRITE, 1, 0, 0, 1));
        add_row(mk(som_pkg::OP_WRITE, 1, 1, 0, 1));
        add_row(mk(som_pkg::OP_WRITE, 2, 0, 16'h8000, 1));
        add_row(mk(som_pkg::OP_WRITE, 2, 1, 16'h8000, 1));
        add_row(mk(som_pkg::OP_WRITE, 3, 0, 0, 1));
        add_row(mk(som_pkg::OP_WRITE, 3, 1, 1, 1));
        add_row(mk(som_pkg::OP_READ, 0, 0, 0, 1), 1, som_pkg::KIND_READ, 16'hFFFF);
        add_row(mk(som_pkg::OP_READ, 1, 1, 0, 1), 1, som_pkg::KIND_READ, 0);
        add_row(mk(som_pkg::OP_WRITE, 63, 255, 16'hABCD, 65535));
        add_row(mk(som_pkg::OP_READ, 63, 255, 16'hFFFF, 65535), 1, som_pkg::KIND_READ,
                16'hABCD);
        add_row(mk(som_pkg::OP_MATCH, 0, 0, 0, 0));
        add_row(mk(som_pkg::OP_MATCH, 0, 1, 0, 0), 1, som_pkg::KIND_MATCH, 0, 1, 0);
        add_row(mk(som_pkg::OP_MATCH, 63, 0, 16'hFFFF, 1));
        add_row(mk(som_pkg::OP_MATCH, 63, 1, 16'hFFFF, 1), 1, som_pkg::KIND_MATCH, 0, 0, 0);
        add_row(mk(som_pkg::OP_TRAIN, 0, 0, 16'h1000, 0));
        add_row(mk(som_pkg::OP_TRAIN, 0, 1, 16'h1000, 65535));
        add_row(mk(som_pkg::OP_READ, 3, 0, 0, 1), 1, som_pkg::KIND_READ, 16'h1000);
        add_row(mk(som_pkg::OP_READ, 1, 0, 0, 1), 1, som_pkg::KIND_READ, 0);
        add_row(mk(som_pkg::OP_MATCH, 0, 1, 0, 1));
        foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
        drain();

        // 4x4 map; hold the receiver off while reads pile up
        set_map(4, 4, 4, 1, 4);
        fill_weights();
        hold_req = 1;
        repeat (12) random_read();
        run_sequences(30);
        drain();

        run_phase(0, 127, 0, 255, 65535, 40);
        run_phase(1, 1, 511, 3, 100, 1);
        run_phase(64, 64, 3, 128, 1, 20);
        run_phase(3, 5, 6, 17, 40, 25);
        quiet = 1;
        run_phase(5, 2, 5, 0, 9, 20);

        $display("covered %0d transfers in, %0d results out, %0d training steps",
                 n_items, n_results, n_train);
        $display("map shapes from 1x1 to 64x64 nodes, vector lengths 1 to 256");
        if (n_fail == 0 && result_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            if (result_q.size() != 0) $error("%0d results never arrived", result_q.size());
            $display("testbench failed");
        end
        $finish;
    end

endmodule
